/* hdl/height_to_colour_ramp_macros.svh */
// Assertion macros for the height to colour ramp checker.
// Needs nothing else; the checker includes this file.
`ifndef HEIGHT_TO_COLOUR_RAMP_MACROS_SVH
`define HEIGHT_TO_COLOUR_RAMP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define HTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("height to colour ramp check failed");

// Next-cycle implication, disabled while in reset.
`define HTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("height to colour ramp check failed");

`endif

/* hdl/htc_pkg.sv */
// Shared types and constants for the height to colour ramp.
// Depends on nothing; used by the interfaces, the top level and the checker.
package htc_pkg;

    localparam int HeightW = 16;
    localparam int ChanW   = 8;
    localparam int PairW   = 48;
    localparam int CfgIdxW = 3;
    localparam int NumChan = 3;
    localparam int QBits   = 8;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_SEA      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_LOWEST   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_HIGHEST  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WATER    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TERRAIN  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_MOUNTAIN = 3'd5;

    // Band codes.
    localparam logic [1:0] BAND_WATER    = 2'd0;
    localparam logic [1:0] BAND_TERRAIN  = 2'd1;
    localparam logic [1:0] BAND_MOUNTAIN = 2'd2;

    // Per-channel state inside the divider.
    typedef struct packed {
        logic [27:0]       rem;
        logic [QBits-1:0]  q;
        logic              sgn;
        logic              sat;
        logic [ChanW-1:0]  base;
    } t_lane;

    // One word inside the divider.
    typedef struct packed {
        logic [18:0]         den;
        logic [1:0]          band;
        logic                fault;
        t_lane [NumChan-1:0] lane;
    } t_div;

endpackage

/* hdl/htc_in_if.sv */
// Input channel of the height to colour ramp: one elevation word.
// Depends on htc_pkg.
interface htc_in_if import htc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [HeightW-1:0] elevation;

    modport source (output valid, output elevation, input ready);
    modport sink (input valid, input elevation, output ready);
endinterface

/* hdl/htc_out_if.sv */
// Output channel of the height to colour ramp: one colour word.
// Depends on htc_pkg.
interface htc_out_if import htc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [1:0]       band;
    logic             divide_fault;

    modport source (output valid, output red, output green, output blue,
                    output band, output divide_fault, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input band, input divide_fault, output ready);
endinterface

/* hdl/height_to_colour_ramp.sv */
// Throughput: one word per cycle, set by the twelve-stage pipeline with one
// quotient bit resolved per divider stage; the whole pipeline holds on a stall.
// Reset (synchronous, active low) empties the pipeline and loads the default
// sea, lowest and highest levels and black colour pairs.
module height_to_colour_ramp import htc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    htc_in_if.sink             i_in,
    htc_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [PairW-1:0]   i_cfg_data
);

    // Configuration registers.
    logic signed [HeightW-1:0] r_sea, r_low, r_high;
    logic [PairW-1:0]          r_water, r_terrain, r_mountain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sea      <= '0;
            r_low      <= -16'sd256;
            r_high     <= 16'sd256;
            r_water    <= '0;
            r_terrain  <= '0;
            r_mountain <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEA:      r_sea      <= i_cfg_data[HeightW-1:0];
                REG_LOWEST:   r_low      <= i_cfg_data[HeightW-1:0];
                REG_HIGHEST:  r_high     <= i_cfg_data[HeightW-1:0];
                REG_WATER:    r_water    <= i_cfg_data;
                REG_TERRAIN:  r_terrain  <= i_cfg_data;
                REG_MOUNTAIN: r_mountain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the output word is held.
    logic en;
    logic r_ov;
    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    // Stage A: band choice, blend position, divisor and colour differences.
    logic signed [19:0] e_x, s_x, l_x, h_x, e5, s5, h3;
    logic               is_water, is_mount;
    logic signed [19:0] n_along, n_den;
    logic [PairW-1:0]   pair;
    logic [1:0]         n_band;

    always_comb begin
        e_x = {{4{i_in.elevation[15]}}, i_in.elevation};
        s_x = {{4{r_sea[15]}}, r_sea};
        l_x = {{4{r_low[15]}}, r_low};
        h_x = {{4{r_high[15]}}, r_high};
        e5  = e_x * 20'sd5;
        s5  = s_x * 20'sd5;
        h3  = h_x * 20'sd3;
        is_water = e_x < s_x;
        is_mount = !is_water && (e5 > h3);
        if (is_water) begin
            n_band  = BAND_WATER;
            pair    = r_water;
            n_along = e_x - l_x;
            n_den   = s_x - l_x;
        end else if (is_mount) begin
            n_band  = BAND_MOUNTAIN;
            pair    = r_mountain;
            n_along = h5_free_along(h_x, e5);
            n_den   = h_x <<< 1;
        end else begin
            n_band  = BAND_TERRAIN;
            pair    = r_terrain;
            n_along = e5 - s5;
            n_den   = h3 - s5;
        end
    end

    // Mountain blend position: five times the distance below the highest level.
    function automatic logic signed [19:0] h5_free_along(logic signed [19:0] h,
                                                         logic signed [19:0] e_times5);
        return (h * 20'sd5) - e_times5;
    endfunction

    logic                      r_av, r_amount;
    logic [1:0]                r_aband;
    logic signed [19:0]        r_aalong, r_aden;
    logic signed [8:0]         r_adiff [NumChan];
    logic [ChanW-1:0]          r_abase [NumChan];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (en) begin
            r_av <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_amount <= is_mount;
            r_aband  <= n_band;
            r_aalong <= n_along;
            r_aden   <= n_den;
            for (int c = 0; c < NumChan; c++) begin
                r_adiff[c] <= $signed({1'b0, pair[24 + (2-c)*8 +: 8]})
                            - $signed({1'b0, pair[(2-c)*8 +: 8]});
                r_abase[c] <= is_mount ? pair[24 + (2-c)*8 +: 8] : pair[(2-c)*8 +: 8];
            end
        end
    end

    // Stage B: products and divisor sign normalisation.
    logic                 r_bv, r_bneg, r_bfault;
    logic [1:0]           r_bband;
    logic [18:0]          r_bden;
    logic signed [28:0]   r_bprod [NumChan];
    logic [ChanW-1:0]     r_bbase [NumChan];
    logic signed [19:0]   den_abs;

    assign den_abs = r_aden[19] ? -r_aden : r_aden;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (en) begin
            r_bv <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bneg   <= r_amount ^ r_aden[19];
            r_bfault <= (r_aden == '0);
            r_bband  <= r_aband;
            r_bden   <= den_abs[18:0];
            for (int c = 0; c < NumChan; c++) begin
                r_bprod[c] <= 29'(r_adiff[c]) * 29'(r_aalong);
                r_bbase[c] <= r_abase[c];
            end
        end
    end

    // Stage C: magnitude, sign and saturation test, then the divider stages.
    t_div r_div [QBits+1];
    logic r_dv  [QBits+1];
    t_div n_div [QBits+1];

    always_comb begin
        logic [28:0] mag;
        logic [27:0] sh;
        n_div[0].den   = r_bden;
        n_div[0].band  = r_bband;
        n_div[0].fault = r_bfault;
        for (int c = 0; c < NumChan; c++) begin
            mag = r_bprod[c][28] ? 29'(-r_bprod[c]) : 29'(r_bprod[c]);
            n_div[0].lane[c].rem  = mag[27:0];
            n_div[0].lane[c].q    = '0;
            n_div[0].lane[c].sgn  = r_bprod[c][28] ^ r_bneg;
            n_div[0].lane[c].sat  = mag[27:0] >= {1'b0, r_bden, 8'b0};
            n_div[0].lane[c].base = r_bbase[c];
        end
        // One quotient bit per stage, most significant first.
        for (int s = 0; s < QBits; s++) begin
            n_div[s+1] = r_div[s];
            sh = 28'(r_div[s].den) << (QBits - 1 - s);
            for (int c = 0; c < NumChan; c++) begin
                if (!r_div[s].lane[c].sat && r_div[s].lane[c].rem >= sh) begin
                    n_div[s+1].lane[c].rem = r_div[s].lane[c].rem - sh;
                    n_div[s+1].lane[c].q[QBits-1-s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QBits; s++) r_dv[s] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_bv;
            for (int s = 0; s < QBits; s++) r_dv[s+1] <= r_dv[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= QBits; s++) r_div[s] <= n_div[s];
        end
    end

    // Final stage: floor correction, offset from the base colour, clamp.
    logic [ChanW-1:0] n_col [NumChan];

    always_comb begin
        logic [8:0]         qmag;
        logic signed [10:0] qs, v;
        for (int c = 0; c < NumChan; c++) begin
            if (r_div[QBits].lane[c].sat) begin
                qmag = 9'd256;
            end else begin
                qmag = {1'b0, r_div[QBits].lane[c].q}
                     + 9'(r_div[QBits].lane[c].sgn && (r_div[QBits].lane[c].rem != '0));
            end
            qs = r_div[QBits].lane[c].sgn ? -$signed({2'b0, qmag}) : $signed({2'b0, qmag});
            v  = $signed({3'b0, r_div[QBits].lane[c].base}) + qs;
            if (r_div[QBits].fault || v < 0) begin
                n_col[c] = '0;
            end else if (v > 11'sd255) begin
                n_col[c] = 8'hFF;
            end else begin
                n_col[c] = v[7:0];
            end
        end
    end

    logic [ChanW-1:0] r_ored, r_ogreen, r_oblue;
    logic [1:0]       r_oband;
    logic             r_ofault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ored   <= n_col[0];
            r_ogreen <= n_col[1];
            r_oblue  <= n_col[2];
            r_oband  <= r_div[QBits].band;
            r_ofault <= r_div[QBits].fault;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.red          = r_ored;
    assign o_out.green        = r_ogreen;
    assign o_out.blue         = r_oblue;
    assign o_out.band         = r_oband;
    assign o_out.divide_fault = r_ofault;

endmodule

/* hdl/htc_checker.sv */
// Port-level checks for the height to colour ramp, bound to the top level.
// Depends on htc_pkg and height_to_colour_ramp_macros.svh.
`include "height_to_colour_ramp_macros.svh"

module htc_checker import htc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [ChanW-1:0] i_red,
    input logic [ChanW-1:0] i_green,
    input logic [ChanW-1:0] i_blue,
    input logic [1:0]       i_band,
    input logic             i_fault
);

    // A faulted word carries black.
    `HTC_ASSERT_NOW(a_fault_black, i_clk, i_rst_n, i_out_valid && i_fault, (i_red == '0) && (i_green == '0) && (i_blue == '0))

    // Only the three defined bands appear.
    `HTC_ASSERT_NOW(a_band_code, i_clk, i_rst_n, i_out_valid, (i_band == BAND_WATER) || (i_band == BAND_TERRAIN) || (i_band == BAND_MOUNTAIN))

    // The input is held back exactly while a finished word waits.
    `HTC_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, 1'b1, i_in_ready == (!i_out_valid || i_out_ready))

    // A stalled word stays on the port.
    `HTC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_red) && $stable(i_band))

endmodule

bind height_to_colour_ramp htc_checker u_htc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_red       (o_out.red),
    .i_green     (o_out.green),
    .i_blue      (o_out.blue),
    .i_band      (o_out.band),
    .i_fault     (o_out.divide_fault)
);

/* verif/tb_top.sv */
// Testbench for the height to colour ramp: directed table, then random words.
// Depends on htc_pkg, htc_in_if, htc_out_if and height_to_colour_ramp.
`timescale 1ns / 100ps

module tb_top;
    import htc_pkg::*;

    localparam int TableLen = 14;
    localparam int Latency  = 11;
    localparam longint CycleLimit = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] band;
        logic       fault;
    } t_colour;

    // One row of the directed table; has_exp marks a typed-in expectation.
    typedef struct {
        logic signed [15:0] elevation;
        bit                 has_exp;
        t_colour            exp;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CfgIdxW-1:0] i_cfg_index = REG_SEA;
    logic [PairW-1:0] i_cfg_data = '0;

    htc_in_if  in_ch();
    htc_out_if out_ch();

    height_to_colour_ramp DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Local copy of the configuration.
    logic signed [15:0] sea_lvl, low_lvl, high_lvl;
    logic [47:0] water_cols, terrain_cols, mountain_cols;

    t_colour colour_q[$];
    int idle_pct, stall_pct;
    bit failed;
    longint cycles;

    function automatic longint floor_quot(longint num, longint den);
        longint q;
        if (den < 0) begin
            den = -den;
            num = -num;
        end
        q = num / den;
        if (num % den != 0 && num < 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [7:0] clamp8(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // Expected colour word for one elevation under the current registers.
    function automatic t_colour ramp_colour(logic signed [15:0] elev);
        t_colour r;
        longint e, sea, low, high, along, den, c0, c1, v;
        logic [47:0] pair;
        logic [7:0] chan [3];
        bit mtn;
        e = elev;
        sea = sea_lvl;
        low = low_lvl;
        high = high_lvl;
        mtn = 0;
        if (e < sea) begin
            r.band = BAND_WATER;
            pair = water_cols;
            along = e - low;
            den = sea - low;
        end else if (5 * e > 3 * high) begin
            r.band = BAND_MOUNTAIN;
            pair = mountain_cols;
            along = 5 * (high - e);
            den = 2 * high;
            mtn = 1;
        end else begin
            r.band = BAND_TERRAIN;
            pair = terrain_cols;
            along = 5 * (e - sea);
            den = 3 * high - 5 * sea;
        end
        r.fault = (den == 0);
        for (int ch = 0; ch < 3; ch++) begin
            c0 = pair[(2 - ch) * 8 +: 8];
            c1 = pair[24 + (2 - ch) * 8 +: 8];
            if (den == 0) v = 0;
            else if (mtn) v = c1 + floor_quot(-((c1 - c0) * along), den);
            else v = c0 + floor_quot((c1 - c0) * along, den);
            chan[ch] = clamp8(v);
        end
        r.red = chan[0];
        r.green = chan[1];
        r.blue = chan[2];
        return r;
    endfunction

    // Register write: the local copy follows the block.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_SEA:      sea_lvl = val[15:0];
            REG_LOWEST:   low_lvl = val[15:0];
            REG_HIGHEST:  high_lvl = val[15:0];
            REG_WATER:    water_cols = val;
            REG_TERRAIN:  terrain_cols = val;
            REG_MOUNTAIN: mountain_cols = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Drops the input valid, then waits until every expected word has come.
    task automatic wait_drained();
        in_ch.valid <= 0;
        while (colour_q.size() != 0) @(negedge i_clk);
        repeat (Latency + 4) @(negedge i_clk);
    endtask

    // Sends one elevation word, with optional typed-in expectation.
    // Valid is left high on return; the next idle cycle or drain drops it.
    task automatic send_height(logic signed [15:0] elev, bit has_exp, t_colour exp);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.elevation <= elev;
        colour_q.push_back(has_exp ? exp : ramp_colour(elev));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_height();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_pair();
        return 48'({$urandom, $urandom});
    endfunction

    // Receiver: random stalls, compare with the oldest expectation.
    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        t_colour got, exp;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.band, out_ch.divide_fault};
            if (colour_q.size() == 0) begin
                $display("%0t: colour word with none expected: %h", $time, got);
                failed = 1;
            end else begin
                exp = colour_q.pop_front();
                if (got !== exp) begin
                    $display("%0t: mismatch exp r%h g%h b%h band%0d f%0b got r%h g%h b%h band%0d f%0b",
                             $time, exp.red, exp.green, exp.blue, exp.band, exp.fault,
                             got.red, got.green, got.blue, got.band, got.fault);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog on a cycle count.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    t_row dir_tab [TableLen];

    initial begin
        t_colour none;
        none = '0;
        failed = 0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        in_ch.valid = 0;
        in_ch.elevation = 0;
        out_ch.ready = 1;
        sea_lvl = 0;
        low_lvl = -256;
        high_lvl = 256;
        water_cols = '0;
        terrain_cols = '0;
        mountain_cols = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // After reset every colour is black; band is read off the levels.
        dir_tab[0] = '{-16'sd1, 1, '{0, 0, 0, BAND_WATER, 0}};
        dir_tab[1] = '{16'sd0, 1, '{0, 0, 0, BAND_TERRAIN, 0}};
        dir_tab[2] = '{16'sd200, 1, '{0, 0, 0, BAND_MOUNTAIN, 0}};
        dir_tab[3] = '{16'sh8000, 1, '{0, 0, 0, BAND_WATER, 0}};
        dir_tab[4] = '{16'sh7fff, 1, '{0, 0, 0, BAND_MOUNTAIN, 0}};
        for (int i = 0; i < 5; i++)
            send_height(dir_tab[i].elevation, dir_tab[i].has_exp, dir_tab[i].exp);
        wait_drained();

        // Colour ramps, water and terrain at full swing; rows checked by the predictor.
        write_reg(REG_WATER, 48'hffffff_000000);
        write_reg(REG_TERRAIN, 48'h00ff00_ff00ff);
        write_reg(REG_MOUNTAIN, 48'h123456_fedcba);
        dir_tab[5] = '{16'sh8000, 0, none};
        dir_tab[6] = '{-16'sd256, 0, none};
        dir_tab[7] = '{-16'sd128, 0, none};
        dir_tab[8] = '{16'sd153, 0, none};
        dir_tab[9] = '{16'sd154, 0, none};
        dir_tab[10] = '{16'sd256, 0, none};
        dir_tab[11] = '{16'sh7fff, 0, none};
        for (int i = 5; i < 12; i++)
            send_height(dir_tab[i].elevation, dir_tab[i].has_exp, dir_tab[i].exp);
        wait_drained();

        // Zero divisors: sea equals lowest, and highest of zero.
        write_reg(REG_LOWEST, 16'sd0);
        write_reg(REG_HIGHEST, 16'sd0);
        dir_tab[12] = '{-16'sd5, 1, '{0, 0, 0, BAND_WATER, 1}};
        dir_tab[13] = '{16'sd5, 1, '{0, 0, 0, BAND_MOUNTAIN, 1}};
        for (int i = 12; i < TableLen; i++)
            send_height(dir_tab[i].elevation, dir_tab[i].has_exp, dir_tab[i].exp);
        // Terrain divisor zero needs 3*high == 5*sea.
        send_height(16'sd0, 1, '{0, 0, 0, BAND_TERRAIN, 1});
        wait_drained();

        // Random phases; settings include the extremes and negative divisors.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            if (ph == 1) begin
                write_reg(REG_SEA, 16'sh7fff);
                write_reg(REG_LOWEST, 16'sh8000);
                write_reg(REG_HIGHEST, 16'sh8000);
            end else if (ph == 2) begin
                write_reg(REG_SEA, 16'sh8000);
                write_reg(REG_LOWEST, 16'sh7fff);
                write_reg(REG_HIGHEST, 16'sh7fff);
            end else begin
                write_reg(REG_SEA, 48'($signed($urandom_range(800)) - 400));
                write_reg(REG_LOWEST, $urandom_range(1) ? 48'($urandom)
                                      : 48'($signed($urandom_range(400)) - 800));
                write_reg(REG_HIGHEST, $urandom_range(1) ? 48'($urandom)
                                       : 48'($urandom_range(1000)));
            end
            write_reg(REG_WATER, rand_pair());
            write_reg(REG_TERRAIN, rand_pair());
            write_reg(REG_MOUNTAIN, ph == 3 ? 48'hffffffffffff : rand_pair());
            for (int k = 0; k < 50; k++) begin
                send_height(rand_height(), 0, none);
                // Hold off once until the pipeline has emptied.
                if (ph == 0 && k == 25) begin
                    in_ch.valid <= 0;
                    do @(negedge i_clk); while (colour_q.size() != 0);
                end
            end
            wait_drained();
        end

        if (!failed) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
